// ===== sv/imu_cf_pkg.sv =====
// Package for the IMU complementary filter: types, codes, reset values
// and the CORDIC arctangent table. No dependencies.
`default_nettype none
package imu_cf_pkg;

  localparam int CALIB_SAMPLES_DEF = 100;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int CFG_W = 20;

  localparam logic [15:0] BLEND_K_RST = 16'd64225;
  localparam logic [19:0] GYRO_SCALE_RST = 20'd4588;

  localparam logic REG_BLEND_K = 1'b0;
  localparam logic REG_GYRO_SCALE = 1'b1;

  localparam logic [1:0] PH_CAL = 2'd0;
  localparam logic [1:0] PH_SEED = 2'd1;
  localparam logic [1:0] PH_FILT = 2'd2;

  typedef enum logic [1:0] {
    KIND_CAL  = 2'd0,
    KIND_SEED = 2'd1,
    KIND_FILT = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [15:0] gx;
    logic signed [15:0] gy;
    logic signed [12:0] ax;
    logic signed [12:0] ay;
    logic signed [12:0] az;
  } q_entry_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
  } bias_t;

  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd377487360;
      5'd1:  v = 32'd222843801;
      5'd2:  v = 32'd117744544;
      5'd3:  v = 32'd59768969;
      5'd4:  v = 32'd30000467;
      5'd5:  v = 32'd15014858;
      5'd6:  v = 32'd7509261;
      5'd7:  v = 32'd3754860;
      5'd8:  v = 32'd1877459;
      5'd9:  v = 32'd938733;
      5'd10: v = 32'd469367;
      5'd11: v = 32'd234683;
      5'd12: v = 32'd117342;
      5'd13: v = 32'd58671;
      5'd14: v = 32'd29335;
      5'd15: v = 32'd14668;
      5'd16: v = 32'd7334;
      5'd17: v = 32'd3667;
      5'd18: v = 32'd1833;
      5'd19: v = 32'd917;
      5'd20: v = 32'd458;
      5'd21: v = 32'd229;
      5'd22: v = 32'd115;
      5'd23: v = 32'd57;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== sv/imu_cf_cdiv.sv =====
// Divider of a signed value by a constant through a reciprocal multiplication.
// Returns the magnitude quotient, the sign and whether a remainder is left.
// Depends on nothing but its parameters.
`default_nettype none
module imu_cf_cdiv #(
  parameter int W = 27,
  parameter int D = 100
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic signed [W-1:0] dividend,
  output logic                     done,
  output logic [W-1:0]             quot,
  output logic                     neg,
  output logic                     rem_nz
);
  localparam int DB = $clog2(D);
  localparam int S = W + DB;
  localparam int MW = W + 1;
  localparam longint unsigned RECIP = ((64'd1 << S) / D) + 1;
  localparam logic [MW-1:0] MC = MW'(RECIP);
  localparam logic [W-1:0] DC = W'(D);

  logic [W-1:0]    mag_r;
  logic            neg_r;
  logic [W+MW-1:0] prod_r;
  logic [W-1:0]    quot_r;
  logic            rem_nz_r;
  logic [2:0]      stg_r;
  logic            done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r <= '0;
      done_r <= 1'b0;
    end else begin
      stg_r <= {stg_r[1:0], start};
      done_r <= stg_r[2];
    end
    if (start) begin
      neg_r <= dividend[W-1];
      mag_r <= dividend[W-1] ? W'(-dividend) : W'(dividend);
    end
    if (stg_r[0]) begin
      prod_r <= mag_r * MC;
    end
    if (stg_r[1]) begin
      quot_r <= W'(prod_r >> S);
    end
    if (stg_r[2]) begin
      rem_nz_r <= (mag_r != W'(quot_r * DC));
    end
  end

  assign done = done_r;
  assign quot = quot_r;
  assign neg = neg_r;
  assign rem_nz = rem_nz_r;
endmodule
`default_nettype wire

// ===== sv/imu_cf_fifo.sv =====
// Short queue between the front and the back part, registered read.
// Depends on nothing but its parameters.
`default_nettype none
module imu_cf_fifo #(
  parameter int DEPTH = 4,
  parameter int W = 73
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] wr_data,
  input  wire logic         pop,
  output logic [W-1:0]      rd_data,
  output logic              full,
  output logic              empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  rd_data_r;
  logic          do_push, do_pop;

  assign full = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + CW'(do_push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp_r] <= wr_data;
    end
    if (do_pop) begin
      rd_data_r <= mem[rp_r];
    end
  end

  assign rd_data = rd_data_r;
endmodule
`default_nettype wire

// ===== sv/imu_cf_front.sv =====
// Front part: accepts samples, keeps the calibration sums and the gyro
// biases, and tags each sample for the back part. Uses imu_cf_pkg, imu_cf_cdiv.
`default_nettype none
module imu_cf_front #(
  parameter int CALIB_SAMPLES = 100
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic [70:0]         in_data,
  output logic                     in_ready,
  input  wire logic                q_full,
  output logic                     q_push,
  output imu_cf_pkg::q_entry_t     q_entry,
  output imu_cf_pkg::bias_t        bias
);
  import imu_cf_pkg::*;

  localparam int CW = $clog2(CALIB_SAMPLES + 1);
  localparam int SW = 16 + CW;

  typedef enum logic [2:0] {
    F_CAL  = 3'b001,
    F_BIAS = 3'b010,
    F_RUN  = 3'b100
  } fstate_t;

  fstate_t              st_r, st_nxt;
  logic                 seeded_r, seeded_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic signed [SW-1:0] sx_r, sx_nxt, sy_r, sy_nxt;
  logic                 start_r, start_nxt;
  bias_t                bias_r, bias_nxt;
  logic                 acc;
  logic                 dx_done, dy_done, dx_neg, dy_neg, dx_nz, dy_nz;
  logic [SW-1:0]        dx_q, dy_q;
  logic signed [15:0]   gx, gy;

  assign gx = in_data[15:0];
  assign gy = in_data[31:16];
  assign in_ready = !q_full && (st_r != F_BIAS);
  assign acc = in_valid && in_ready;

  always_comb begin
    st_nxt = st_r;
    seeded_nxt = seeded_r;
    cnt_nxt = cnt_r;
    sx_nxt = sx_r;
    sy_nxt = sy_r;
    start_nxt = 1'b0;
    bias_nxt = bias_r;
    q_push = 1'b0;
    q_entry.kind = KIND_CAL;
    q_entry.gx = gx;
    q_entry.gy = gy;
    q_entry.ax = in_data[44:32];
    q_entry.ay = in_data[57:45];
    q_entry.az = in_data[70:58];
    case (st_r)
      F_CAL: begin
        if (acc) begin
          q_push = 1'b1;
          sx_nxt = sx_r + SW'(gx);
          sy_nxt = sy_r + SW'(gy);
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_nxt >= CW'(CALIB_SAMPLES)) begin
            cnt_nxt = '0;
            start_nxt = 1'b1;
            st_nxt = F_BIAS;
          end
        end
      end
      F_BIAS: begin
        if (dx_done) begin
          bias_nxt.x = dx_neg ? 16'(-dx_q) : 16'(dx_q);
          bias_nxt.y = dy_neg ? 16'(-dy_q) : 16'(dy_q);
          st_nxt = F_RUN;
        end
      end
      F_RUN: begin
        q_entry.kind = seeded_r ? KIND_FILT : KIND_SEED;
        if (acc) begin
          q_push = 1'b1;
          seeded_nxt = 1'b1;
        end
      end
      default: st_nxt = F_CAL;
    endcase
  end

  imu_cf_cdiv #(.W(SW), .D(CALIB_SAMPLES)) u_div_x (
    .clk(clk), .rst_n(rst_n), .start(start_r), .dividend(sx_r),
    .done(dx_done), .quot(dx_q), .neg(dx_neg), .rem_nz(dx_nz)
  );

  imu_cf_cdiv #(.W(SW), .D(CALIB_SAMPLES)) u_div_y (
    .clk(clk), .rst_n(rst_n), .start(start_r), .dividend(sy_r),
    .done(dy_done), .quot(dy_q), .neg(dy_neg), .rem_nz(dy_nz)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= F_CAL;
      seeded_r <= 1'b0;
      cnt_r <= '0;
      sx_r <= '0;
      sy_r <= '0;
      start_r <= 1'b0;
      bias_r <= '0;
    end else begin
      st_r <= st_nxt;
      seeded_r <= seeded_nxt;
      cnt_r <= cnt_nxt;
      sx_r <= sx_nxt;
      sy_r <= sy_nxt;
      start_r <= start_nxt;
      bias_r <= bias_nxt;
    end
  end

  assign bias = bias_r;
endmodule
`default_nettype wire

// ===== sv/imu_cf_back.sv =====
// Back part: square roots, CORDIC, gyro rates and the blend for one sample,
// with the output register. Uses imu_cf_pkg and imu_cf_cdiv.
`default_nettype none
module imu_cf_back #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 q_empty,
  input  wire imu_cf_pkg::q_entry_t q_data,
  output logic                      q_pop,
  input  wire imu_cf_pkg::bias_t    bias,
  input  wire logic [15:0]          blend_k,
  input  wire logic [19:0]          gyro_scale,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [55:0]               out_data,
  output logic [1:0]                out_phase
);
  import imu_cf_pkg::*;

  localparam int NSTEP = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
  localparam int SQ_N = 28;

  typedef enum logic [10:0] {
    B_IDLE = 11'b00000000001,
    B_LOAD = 11'b00000000010,
    B_SQR  = 11'b00000000100,
    B_SUM  = 11'b00000001000,
    B_SQRT = 11'b00000010000,
    B_CORD = 11'b00000100000,
    B_RATE = 11'b00001000000,
    B_SAT  = 11'b00010000000,
    B_TERM = 11'b00100000000,
    B_MUL  = 11'b01000000000,
    B_DIV  = 11'b10000000000
  } bstate_t;

  function automatic logic signed [23:0] sat24(input logic signed [37:0] v);
    if (v > 38'sd8388607) return 24'sh7fffff;
    if (v < -38'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [27:0] v);
    if (v > 28'sd32767) return 16'sh7fff;
    if (v < -28'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  bstate_t            st_r, st_nxt;
  logic               pend_r;
  q_entry_t           e_r;
  logic [24:0]        sqx_r, sqy_r, sqz_r;
  logic [55:0]        rad1_r, rad2_r;
  logic [29:0]        rem1_r, rem2_r, rem1_n, rem2_n, t1, t2, tr1, tr2;
  logic [27:0]        root1_r, root2_r, root1_n, root2_n;
  logic [4:0]         cnt_r;
  logic signed [31:0] x1_r, y1_r, z1_r, x2_r, y2_r, z2_r;
  logic signed [31:0] x1_n, y1_n, z1_n, x2_n, y2_n, z2_n, at;
  logic signed [37:0] px_r, py_r;
  logic signed [23:0] rx_r, ry_r;
  logic signed [15:0] acc1_r, acc2_r, roll_r, pitch_r;
  logic signed [25:0] tr_r, tp_r;
  logic signed [23:0] ar_r, ap_r;
  logic signed [41:0] m1_r, m2_r, m3_r, m4_r;
  logic               dstart_r, dr_done, dp_done, dr_neg, dp_neg, dr_nz, dp_nz;
  logic [26:0]        dr_q, dp_q;
  logic               out_valid_r;
  logic [55:0]        out_data_r;
  logic [1:0]         out_phase_r;
  logic               out_free;

  assign out_free = !out_valid_r || out_ready;
  assign q_pop = (st_r == B_IDLE) && !pend_r && !q_empty;

  always_comb begin
    t1 = {rem1_r[27:0], rad1_r[55:54]};
    t2 = {rem2_r[27:0], rad2_r[55:54]};
    tr1 = {root1_r, 2'b01};
    tr2 = {root2_r, 2'b01};
    if (t1 >= tr1) begin
      rem1_n = t1 - tr1;
      root1_n = {root1_r[26:0], 1'b1};
    end else begin
      rem1_n = t1;
      root1_n = {root1_r[26:0], 1'b0};
    end
    if (t2 >= tr2) begin
      rem2_n = t2 - tr2;
      root2_n = {root2_r[26:0], 1'b1};
    end else begin
      rem2_n = t2;
      root2_n = {root2_r[26:0], 1'b0};
    end
  end

  always_comb begin
    at = $signed(atan_entry(cnt_r));
    x1_n = x1_r;
    y1_n = y1_r;
    z1_n = z1_r;
    x2_n = x2_r;
    y2_n = y2_r;
    z2_n = z2_r;
    if (y1_r > 0) begin
      x1_n = x1_r + (y1_r >>> cnt_r);
      y1_n = y1_r - (x1_r >>> cnt_r);
      z1_n = z1_r + at;
    end else if (y1_r < 0) begin
      x1_n = x1_r - (y1_r >>> cnt_r);
      y1_n = y1_r + (x1_r >>> cnt_r);
      z1_n = z1_r - at;
    end
    if (y2_r > 0) begin
      x2_n = x2_r + (y2_r >>> cnt_r);
      y2_n = y2_r - (x2_r >>> cnt_r);
      z2_n = z2_r + at;
    end else if (y2_r < 0) begin
      x2_n = x2_r - (y2_r >>> cnt_r);
      y2_n = y2_r + (x2_r >>> cnt_r);
      z2_n = z2_r - at;
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      B_IDLE: if (q_pop) st_nxt = B_LOAD;
      B_LOAD: st_nxt = (q_data.kind == KIND_CAL) ? B_IDLE : B_SQR;
      B_SQR:  st_nxt = B_SUM;
      B_SUM:  st_nxt = B_SQRT;
      B_SQRT: if (cnt_r == 5'(SQ_N - 1)) st_nxt = B_CORD;
      B_CORD: if (cnt_r == 5'(NSTEP - 1)) st_nxt = B_RATE;
      B_RATE: st_nxt = B_SAT;
      B_SAT:  st_nxt = B_TERM;
      B_TERM: st_nxt = B_MUL;
      B_MUL:  st_nxt = B_DIV;
      B_DIV:  if (dr_done) st_nxt = B_IDLE;
      default: st_nxt = B_IDLE;
    endcase
  end

  logic signed [15:0] roll_q, pitch_q, prev_r, prev_p;
  logic signed [43:0] sr, sp;
  logic signed [16:0] dgx, dgy;
  logic [16:0]        km;
  logic [30:0]        n2;
  logic [25:0]        n1;

  imu_cf_cdiv #(.W(27), .D(100)) u_div_r (
    .clk(clk), .rst_n(rst_n), .start(dstart_r), .dividend(sr[42:16]),
    .done(dr_done), .quot(dr_q), .neg(dr_neg), .rem_nz(dr_nz)
  );

  imu_cf_cdiv #(.W(27), .D(100)) u_div_p (
    .clk(clk), .rst_n(rst_n), .start(dstart_r), .dividend(sp[42:16]),
    .done(dp_done), .quot(dp_q), .neg(dp_neg), .rem_nz(dp_nz)
  );

  always_comb begin
    roll_q = sat16(dr_neg ? -(28'(dr_q) + 28'(dr_nz)) : 28'(dr_q));
    pitch_q = sat16(dp_neg ? -(28'(dp_q) + 28'(dp_nz)) : 28'(dp_q));
    prev_r = (e_r.kind == KIND_SEED) ? acc1_r : roll_r;
    prev_p = (e_r.kind == KIND_SEED) ? acc2_r : pitch_r;
    sr = 44'(m1_r) + 44'(m2_r) + 44'sd3276800;
    sp = 44'(m3_r) + 44'(m4_r) + 44'sd3276800;
    dgx = 17'(e_r.gx) - 17'(bias.x);
    dgy = 17'(e_r.gy) - 17'(bias.y);
    km = 17'd65536 - 17'(blend_k);
    n1 = 26'(sqy_r) + 26'(sqz_r);
    n2 = 31'(sqz_r) * 31'd100 + 31'(sqx_r);
  end

  always_ff @(posedge clk) begin
    dstart_r <= (st_r == B_MUL);
    case (st_r)
      B_LOAD: e_r <= q_data;
      B_SQR: begin
        sqx_r <= 25'(e_r.ax * e_r.ax);
        sqy_r <= 25'(e_r.ay * e_r.ay);
        sqz_r <= 25'(e_r.az * e_r.az);
      end
      B_SUM: begin
        rad1_r <= {6'd0, n1, 24'd0};
        rad2_r <= {1'b0, n2, 24'd0};
        rem1_r <= '0;
        rem2_r <= '0;
        root1_r <= '0;
        root2_r <= '0;
        y1_r <= -(32'(e_r.ax) <<< 12);
        y2_r <= 32'(e_r.ay) * 32'sd40960;
        z1_r <= '0;
        z2_r <= '0;
      end
      B_SQRT: begin
        rad1_r <= {rad1_r[53:0], 2'b00};
        rad2_r <= {rad2_r[53:0], 2'b00};
        rem1_r <= rem1_n;
        rem2_r <= rem2_n;
        root1_r <= root1_n;
        root2_r <= root2_n;
        x1_r <= 32'(root1_n);
        x2_r <= 32'(root2_n);
      end
      B_CORD: begin
        x1_r <= x1_n;
        y1_r <= y1_n;
        z1_r <= z1_n;
        x2_r <= x2_n;
        y2_r <= y2_n;
        z2_r <= z2_n;
      end
      B_RATE: begin
        px_r <= 38'(dgx) * 38'($signed({1'b0, gyro_scale}));
        py_r <= 38'(dgy) * 38'($signed({1'b0, gyro_scale}));
        acc1_r <= 16'((z1_r + 32'sd32768) >>> 16);
        acc2_r <= 16'((z2_r + 32'sd32768) >>> 16);
      end
      B_SAT: begin
        rx_r <= sat24((px_r + 38'sd256) >>> 9);
        ry_r <= sat24((py_r + 38'sd256) >>> 9);
      end
      B_TERM: begin
        tr_r <= 26'(prev_r) * 26'sd100 + 26'(ry_r);
        tp_r <= 26'(prev_p) * 26'sd100 + 26'(rx_r);
        ar_r <= 24'(acc1_r) * 24'sd100;
        ap_r <= 24'(acc2_r) * 24'sd100;
      end
      B_MUL: begin
        m1_r <= 42'($signed({1'b0, blend_k})) * 42'(tr_r);
        m2_r <= 42'($signed({1'b0, km})) * 42'(ar_r);
        m3_r <= 42'($signed({1'b0, blend_k})) * 42'(tp_r);
        m4_r <= 42'($signed({1'b0, km})) * 42'(ap_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE;
      cnt_r <= '0;
      pend_r <= 1'b0;
      out_valid_r <= 1'b0;
      roll_r <= '0;
      pitch_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r != st_nxt) begin
        cnt_r <= '0;
      end else if (st_r == B_SQRT || st_r == B_CORD) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (pend_r && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (st_r == B_LOAD && q_data.kind == KIND_CAL) begin
        pend_r <= 1'b1;
        out_data_r <= '0;
        out_phase_r <= PH_CAL;
      end
      if (st_r == B_DIV && dr_done) begin
        roll_r <= roll_q;
        pitch_r <= pitch_q;
        pend_r <= 1'b1;
        out_data_r <= {rx_r, pitch_q, roll_q};
        out_phase_r <= (e_r.kind == KIND_SEED) ? PH_SEED : PH_FILT;
      end
      if (pend_r && out_free) begin
        pend_r <= 1'b0;
      end
    end
  end

  logic [55:0] od_r;
  logic [1:0]  op_r;
  always_ff @(posedge clk) begin
    if (pend_r && out_free) begin
      od_r <= out_data_r;
      op_r <= out_phase_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = od_r;
  assign out_phase = op_r;
endmodule
`default_nettype wire

// ===== sv/imu_complementary_filter_top.sv =====
// Top level of the IMU complementary tilt filter: configuration registers,
// front part, queue and back part. Uses imu_cf_pkg and all imu_cf_ modules.
//
//   channel | direction | handshake             | payload
//   in_     | slave     | in_tvalid/in_tready   | in_tdata: gyro_x, gyro_y, accel_x..z
//   out_    | master    | out_tvalid/out_tready | out_tdata: roll, pitch, rate_x
//   cfg_    | write     | cfg_we                | cfg_index, cfg_wdata
//
// A filtering transaction holds the back part for 28 square root steps, the arctangent
// steps, a division by 100 and the load, square, sum, rate, saturation, term and
// multiply states; out_tvalid rises once the result has passed the pending register
// and the output is free. Calibration transactions pass only through the load state
// of the back part; the last one starts a bias division during which the input is
// held. Reset is synchronous, active low. The queue lets the front keep taking
// samples while the back or the output stalls.
`default_nettype none
module imu_complementary_filter_top #(
  parameter int CALIB_SAMPLES = imu_cf_pkg::CALIB_SAMPLES_DEF,
  parameter int CORDIC_STEPS = imu_cf_pkg::CORDIC_STEPS_DEF,
  parameter int QUEUE_DEPTH = imu_cf_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  // gyro_x[15:0], gyro_y[31:16], accel_x[44:32], accel_y[57:45], accel_z[70:58]
  input  wire logic [71:0]                  in_tdata,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  // roll_angle[15:0], pitch_angle[31:16], rate_x[55:32]
  output logic [55:0]                       out_tdata,
  // phase[1:0]
  output logic [1:0]                        out_tuser,
  input  wire logic                         cfg_we,
  input  wire logic                         cfg_index,
  input  wire logic [imu_cf_pkg::CFG_W-1:0] cfg_wdata
);
  import imu_cf_pkg::*;

  logic [15:0] blend_k_r;
  logic [19:0] gyro_scale_r;
  logic        q_push, q_pop, q_full, q_empty;
  q_entry_t    q_in, q_out;
  bias_t       bias;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blend_k_r <= BLEND_K_RST;
      gyro_scale_r <= GYRO_SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BLEND_K:    blend_k_r <= cfg_wdata[15:0];
        REG_GYRO_SCALE: gyro_scale_r <= cfg_wdata[19:0];
        default: ;
      endcase
    end
  end

  imu_cf_front #(.CALIB_SAMPLES(CALIB_SAMPLES)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_data(in_tdata[70:0]),
    .in_ready(in_tready), .q_full(q_full), .q_push(q_push), .q_entry(q_in),
    .bias(bias)
  );

  imu_cf_fifo #(.DEPTH(QUEUE_DEPTH), .W($bits(q_entry_t))) u_fifo (
    .clk(clk), .rst_n(rst_n), .push(q_push), .wr_data(q_in), .pop(q_pop),
    .rd_data(q_out), .full(q_full), .empty(q_empty)
  );

  imu_cf_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_data(q_out), .q_pop(q_pop),
    .bias(bias), .blend_k(blend_k_r), .gyro_scale(gyro_scale_r),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_data(out_tdata),
    .out_phase(out_tuser)
  );
endmodule
`default_nettype wire
